### rtl/core/rlfr_pkg.sv
// ----------------------------------------------------------------------------
// rlfr_pkg: shared types and constants for the RGBA fade ramp
// Mode codes, fade phases, sequencer states and divider status.
// ----------------------------------------------------------------------------
`default_nettype none

package rlfr_pkg;

  localparam int unsigned LengthBitsDef   = 16;
  localparam int unsigned FractionBitsDef = 16;
  localparam int unsigned NumChannels     = 4;
  localparam int unsigned ChanBits        = 8;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_OUT  = 2'd1;
  localparam logic [1:0] MODE_IN   = 2'd2;

  localparam logic [1:0] CH_LAST = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_OUT  = 2'd1,
    PH_IN   = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_TICK = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

### rtl/core/rlfr_div.sv
// ----------------------------------------------------------------------------
// rlfr_div: serial unsigned restoring divider
// One quotient bit per cycle; quotient valid while done is high.
// ----------------------------------------------------------------------------
`default_nettype none

module rlfr_div import rlfr_pkg::*; #(
  parameter int unsigned NumW = 24,
  parameter int unsigned DenW = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic      [NumW-1:0] quo_o,
  output div_sts_t             sts_o
);

  localparam int unsigned CntW = $clog2(NumW);

  logic [NumW-1:0] quo_q;
  logic [DenW-1:0] rem_q, den_q, rem_d;
  logic [CntW-1:0] cnt_q;
  logic            run_q, done_q;
  logic [DenW:0]   part, trial;
  logic            qbit;

  assign part  = {rem_q, quo_q[NumW-1]};
  assign trial = part - {1'b0, den_q};
  assign qbit  = ~trial[DenW];
  assign rem_d = qbit ? trial[DenW-1:0] : part[DenW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(NumW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (run_q) begin
      quo_q <= {quo_q[NumW-2:0], qbit};
      rem_q <= rem_d;
    end
  end

  assign quo_o      = quo_q;
  assign sts_o.busy = run_q;
  assign sts_o.done = done_q;

endmodule

`default_nettype wire

### rtl/core/rgba_linear_fade_ramp_top.sv
// ----------------------------------------------------------------------------
// rgba_linear_fade_ramp_top: four-channel RGBA linear fade ramp
// Tick: while a fade runs, the four channel adds share one adder; a tick that
// ends the fade, a tick while idle and an unused mode use no adds.
// Fade-out: four step divisions, one per channel, on one serial divider;
// fade-in: one alpha division. One transaction in the sequencer at a time;
// reset clears control and fade state, not result registers or divider data.
// ----------------------------------------------------------------------------
`default_nettype none

module rgba_linear_fade_ramp_top import rlfr_pkg::*; #(
  parameter int unsigned LENGTH_BITS   = LengthBitsDef,
  parameter int unsigned FRACTION_BITS = FractionBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [7:0]  start_red_i,
  input  wire logic [7:0]  start_green_i,
  input  wire logic [7:0]  start_blue_i,
  input  wire logic [7:0]  start_alpha_i,
  input  wire logic [7:0]  end_red_i,
  input  wire logic [7:0]  end_green_i,
  input  wire logic [7:0]  end_blue_i,
  input  wire logic [7:0]  end_alpha_i,
  input  wire logic [15:0] length_ticks_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       red_out_o,
  output logic [7:0]       green_out_o,
  output logic [7:0]       blue_out_o,
  output logic [7:0]       alpha_out_o,
  output logic             busy_res_o,
  output logic             shown_o,
  output logic             finished_o
);

  localparam int unsigned AccW  = ChanBits + FRACTION_BITS;
  localparam int unsigned StepW = AccW + 1;

  state_e                 state_q;
  phase_e                 phase_q;
  logic [1:0]             ch_q;
  logic                   div_start_q, visible_q, fin_q;
  logic [LENGTH_BITS-1:0] len_q, ticks_done_q, ticks_total_q, ticks_next, len_in;
  logic [AccW-1:0]        accum_q [NumChannels];
  logic [AccW-1:0]        target_q [NumChannels];
  logic [StepW-1:0]       step_q [NumChannels];
  logic [ChanBits-1:0]    start_col [NumChannels];
  logic [ChanBits-1:0]    end_col [NumChannels];

  logic                   out_valid_q, out_fin_q, out_busy_q, out_shown_q;
  logic [ChanBits-1:0]    out_col_q [NumChannels];

  logic signed [ChanBits:0] diff;
  logic [ChanBits-1:0]      diff_abs;
  logic [AccW-1:0]          num;
  logic                     neg;
  logic [AccW-1:0]          quo;
  logic [StepW-1:0]         q_ext, step_new;
  div_sts_t                 div_sts;
  logic                     out_free;

  assign start_col[0] = start_red_i;
  assign start_col[1] = start_green_i;
  assign start_col[2] = start_blue_i;
  assign start_col[3] = start_alpha_i;
  assign end_col[0]   = end_red_i;
  assign end_col[1]   = end_green_i;
  assign end_col[2]   = end_blue_i;
  assign end_col[3]   = end_alpha_i;

  assign len_in     = LENGTH_BITS'(length_ticks_i);
  assign ticks_next = ticks_done_q + LENGTH_BITS'(1);

  assign diff = signed'({1'b0, target_q[ch_q][AccW-1:FRACTION_BITS]})
              - signed'({1'b0, accum_q[ch_q][AccW-1:FRACTION_BITS]});
  assign diff_abs = diff[ChanBits] ? ChanBits'(-diff) : diff[ChanBits-1:0];
  assign neg      = (phase_q == PH_IN) || diff[ChanBits];
  assign num      = (phase_q == PH_IN) ? accum_q[ch_q]
                                       : {diff_abs, {FRACTION_BITS{1'b0}}};

  rlfr_div #(
    .NumW(AccW),
    .DenW(LENGTH_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start_q),
    .num_i  (num),
    .den_i  (len_q),
    .quo_o  (quo),
    .sts_o  (div_sts)
  );

  assign q_ext    = {1'b0, quo};
  assign step_new = (len_q == '0) ? '0 : (neg ? -q_ext : q_ext);
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      phase_q       <= PH_IDLE;
      ch_q          <= '0;
      div_start_q   <= 1'b0;
      visible_q     <= 1'b0;
      fin_q         <= 1'b0;
      len_q         <= '0;
      ticks_done_q  <= '0;
      ticks_total_q <= '0;
      out_valid_q   <= 1'b0;
      for (int c = 0; c < NumChannels; c++) begin
        accum_q[c]  <= '0;
        target_q[c] <= '0;
        step_q[c]   <= '0;
      end
    end else begin
      div_start_q <= 1'b0;
      if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            len_q <= len_in;
            fin_q <= 1'b0;
            state_q <= ST_DONE;
            case (mode_i)
              MODE_OUT: begin
                phase_q       <= PH_OUT;
                ticks_done_q  <= '0;
                ticks_total_q <= len_in;
                visible_q     <= 1'b1;
                for (int c = 0; c < NumChannels; c++) begin
                  accum_q[c]  <= {start_col[c], {FRACTION_BITS{1'b0}}};
                  target_q[c] <= {end_col[c], {FRACTION_BITS{1'b0}}};
                end
                ch_q        <= '0;
                div_start_q <= 1'b1;
                state_q     <= ST_DIV;
              end
              MODE_IN: begin
                phase_q       <= PH_IN;
                ticks_done_q  <= '0;
                ticks_total_q <= len_in;
                visible_q     <= 1'b1;
                for (int c = 0; c < NumChannels - 1; c++) begin
                  target_q[c] <= accum_q[c];
                  step_q[c]   <= '0;
                end
                target_q[CH_LAST] <= '0;
                ch_q        <= CH_LAST;
                div_start_q <= 1'b1;
                state_q     <= ST_DIV;
              end
              MODE_TICK: begin
                if (phase_q != PH_IDLE) begin
                  if (ticks_next < ticks_total_q) begin
                    ticks_done_q <= ticks_next;
                    ch_q         <= '0;
                    state_q      <= ST_TICK;
                  end else begin
                    ticks_done_q  <= '0;
                    ticks_total_q <= '0;
                    for (int c = 0; c < NumChannels; c++) begin
                      accum_q[c] <= target_q[c];
                    end
                    phase_q <= PH_IDLE;
                    fin_q   <= 1'b1;
                  end
                end
              end
              default: begin
                fin_q <= 1'b0;
              end
            endcase
          end
        end
        ST_DIV: begin
          if (div_sts.done) begin
            step_q[ch_q] <= step_new;
            if (ch_q == CH_LAST) begin
              state_q <= ST_DONE;
            end else begin
              ch_q        <= ch_q + 2'd1;
              div_start_q <= 1'b1;
            end
          end
        end
        ST_TICK: begin
          accum_q[ch_q] <= accum_q[ch_q] + step_q[ch_q][AccW-1:0];
          ch_q          <= ch_q + 2'd1;
          if (ch_q == CH_LAST) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      for (int c = 0; c < NumChannels; c++) begin
        out_col_q[c] <= accum_q[c][AccW-1:FRACTION_BITS];
      end
      out_busy_q  <= (phase_q != PH_IDLE);
      out_shown_q <= visible_q;
      out_fin_q   <= fin_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_col_q[0];
  assign green_out_o = out_col_q[1];
  assign blue_out_o  = out_col_q[2];
  assign alpha_out_o = out_col_q[3];
  assign busy_res_o  = out_busy_q;
  assign shown_o     = out_shown_q;
  assign finished_o  = out_fin_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_div_in_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_sts.busy || div_sts.done) |-> state_q == ST_DIV)
    else $error("divider active outside division phase");

  a_idle_counts_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> (ticks_done_q == '0 && ticks_total_q == '0))
    else $error("tick counters not clear while idle");

  a_fin_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && finished_o) |-> !busy_res_o)
    else $error("finished transaction reports busy");

endmodule

`default_nettype wire

### bench/rgba_linear_fade_ramp_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgba_linear_fade_ramp_top_tb: self-checking bench for the RGBA fade ramp
// Drives fade-out and fade-in requests, ticks and unused modes through the
// valid/stall input channel. A scoreboard class keeps its own copy of the
// 8.16 accumulators, targets and steps and checks every result in order.
// Both channels idle at random outside one window each; the result side also
// holds off once for a long stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------

module rgba_linear_fade_ramp_top_tb;
  import rlfr_pkg::*;

  localparam int FRAC          = FractionBitsDef;
  localparam int ACC_W         = ChanBits + FRAC;
  localparam int STEP_W        = ACC_W + 1;
  localparam int RANDOM_ITEMS  = 420;
  localparam int REPORT_LIMIT  = 10;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 200;
  localparam int IDLE_PERCENT  = 29;
  localparam int LIMIT_NS      = 10_000_000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]      mode;
    logic [3:0][7:0] start_col;
    logic [3:0][7:0] end_col;
    logic [15:0]     length;
  } fade_item_t;

  typedef struct packed {
    logic [3:0][7:0] colour;
    logic            busy;
    logic            shown;
    logic            finished;
  } fade_result_t;

  class fade_scoreboard;
    logic [ACC_W-1:0]  accum [4];
    logic [ACC_W-1:0]  target [4];
    logic signed [STEP_W-1:0] step [4];
    logic [15:0]       ticks_done;
    logic [15:0]       ticks_total;
    phase_e            phase;
    bit                visible;
    fade_result_t      pending_colours [$];
    int                errors;
    int                results_seen;
    int                fades_done;
    int                mode_count [4];

    function new();
      for (int c = 0; c < 4; c++) begin
        accum[c]  = '0;
        target[c] = '0;
        step[c]   = '0;
        mode_count[c] = 0;
      end
      ticks_done   = '0;
      ticks_total  = '0;
      phase        = PH_IDLE;
      visible      = 1'b0;
      errors       = 0;
      results_seen = 0;
      fades_done   = 0;
    endfunction

    function longint ramp_step(longint num, logic [15:0] len);
      if (len == 16'd0) return 0;
      return num / longint'(len);
    endfunction

    function void note_item(fade_item_t it);
      fade_result_t want;
      want.finished = 1'b0;
      mode_count[it.mode]++;
      case (it.mode)
        MODE_OUT: begin
          phase       = PH_OUT;
          ticks_done  = '0;
          ticks_total = it.length;
          for (int c = 0; c < 4; c++) begin
            accum[c]  = {it.start_col[c], {FRAC{1'b0}}};
            target[c] = {it.end_col[c], {FRAC{1'b0}}};
            step[c]   = STEP_W'(ramp_step((longint'(it.end_col[c])
                                           - longint'(it.start_col[c]))
                                          * (longint'(1) << FRAC), it.length));
          end
          visible = 1'b1;
        end
        MODE_IN: begin
          phase       = PH_IN;
          ticks_done  = '0;
          ticks_total = it.length;
          for (int c = 0; c < 3; c++) begin
            target[c] = accum[c];
            step[c]   = '0;
          end
          target[3] = '0;
          step[3]   = STEP_W'(ramp_step(-longint'(accum[3]), it.length));
          visible   = 1'b1;
        end
        MODE_TICK: begin
          if (phase != PH_IDLE) begin
            ticks_done = ticks_done + 16'd1;
            if (ticks_done < ticks_total) begin
              for (int c = 0; c < 4; c++) accum[c] = accum[c] + step[c][ACC_W-1:0];
            end else begin
              ticks_done  = '0;
              ticks_total = '0;
              for (int c = 0; c < 4; c++) accum[c] = target[c];
              phase = PH_IDLE;
              want.finished = 1'b1;
              fades_done++;
            end
          end
        end
        default: ;
      endcase
      for (int c = 0; c < 4; c++) want.colour[c] = accum[c][ACC_W-1 -: 8];
      want.busy  = (phase != PH_IDLE);
      want.shown = visible;
      pending_colours.push_back(want);
    endfunction

    function void check_colour(fade_result_t got);
      fade_result_t want;
      results_seen++;
      if (pending_colours.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected result abgr=%h busy=%b shown=%b fin=%b",
                   got.colour, got.busy, got.shown, got.finished);
        return;
      end
      want = pending_colours.pop_front();
      if (got.colour[0] !== want.colour[0] || got.colour[1] !== want.colour[1] ||
          got.colour[2] !== want.colour[2] || got.colour[3] !== want.colour[3] ||
          got.busy !== want.busy || got.shown !== want.shown ||
          got.finished !== want.finished) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display({"mismatch on result %0d: expected abgr=%h busy=%b shown=%b fin=%b,",
                    " got abgr=%h busy=%b shown=%b fin=%b"},
                   results_seen, want.colour, want.busy, want.shown, want.finished,
                   got.colour, got.busy, got.shown, got.finished);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [1:0]  mode_i         = MODE_TICK;
  logic [7:0]  start_red_i    = '0;
  logic [7:0]  start_green_i  = '0;
  logic [7:0]  start_blue_i   = '0;
  logic [7:0]  start_alpha_i  = '0;
  logic [7:0]  end_red_i      = '0;
  logic [7:0]  end_green_i    = '0;
  logic [7:0]  end_blue_i     = '0;
  logic [7:0]  end_alpha_i    = '0;
  logic [15:0] length_ticks_i = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [7:0]  red_out_o;
  logic [7:0]  green_out_o;
  logic [7:0]  blue_out_o;
  logic [7:0]  alpha_out_o;
  logic        busy_res_o;
  logic        shown_o;
  logic        finished_o;

  fade_scoreboard ramp_sb = new();
  int items_sent = 0;
  bit pressure_done = 1'b0;

  rgba_linear_fade_ramp_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .start_red_i    (start_red_i),
    .start_green_i  (start_green_i),
    .start_blue_i   (start_blue_i),
    .start_alpha_i  (start_alpha_i),
    .end_red_i      (end_red_i),
    .end_green_i    (end_green_i),
    .end_blue_i     (end_blue_i),
    .end_alpha_i    (end_alpha_i),
    .length_ticks_i (length_ticks_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_out_o      (red_out_o),
    .green_out_o    (green_out_o),
    .blue_out_o     (blue_out_o),
    .alpha_out_o    (alpha_out_o),
    .busy_res_o     (busy_res_o),
    .shown_o        (shown_o),
    .finished_o     (finished_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic send_item(input fade_item_t it);
    while (!(items_sent >= 200 && items_sent < 300) &&
           $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    mode_i         <= it.mode;
    start_red_i    <= it.start_col[0];
    start_green_i  <= it.start_col[1];
    start_blue_i   <= it.start_col[2];
    start_alpha_i  <= it.start_col[3];
    end_red_i      <= it.end_col[0];
    end_green_i    <= it.end_col[1];
    end_blue_i     <= it.end_col[2];
    end_alpha_i    <= it.end_col[3];
    length_ticks_i <= it.length;
    in_valid_i     <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ramp_sb.note_item(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_fade(input logic [1:0] mode, input logic [31:0] from_c,
                           input logic [31:0] to_c, input logic [15:0] len);
    fade_item_t it;
    it.mode      = mode;
    it.start_col = from_c;
    it.end_col   = to_c;
    it.length    = len;
    send_item(it);
  endtask

  task automatic send_mode(input logic [1:0] mode, input logic [15:0] len);
    send_fade(mode, $urandom, $urandom, len);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_mode(MODE_TICK, 16'($urandom));
  endtask

  function automatic logic [15:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'd0;
    if (r < 80) return 16'($urandom_range(1, 8));
    if (r < 95) return 16'($urandom_range(9, 40));
    return 16'($urandom);
  endfunction

  task automatic run_directed();
    send_mode(MODE_TICK, 16'hFFFF);
    send_mode(MODE_UNUSED, 16'd3);
    send_fade(MODE_OUT, 32'h0000_0000, 32'hFFFF_FFFF, 16'd1);
    send_ticks(2);
    // zero length: ends on the next tick
    send_fade(MODE_OUT, 32'hFFFF_FFFF, 32'h0000_0000, 16'd0);
    send_ticks(1);
    send_fade(MODE_OUT, 32'hFF80_00FF, 32'h017F_FF00, 16'd3);
    send_ticks(3);
    send_fade(MODE_IN, 32'h0, 32'h0, 16'd2);
    send_ticks(2);
    send_fade(MODE_OUT, 32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF);
    send_ticks(1);
    send_mode(MODE_UNUSED, 16'hFFFF);
    // restart while fading
    send_mode(MODE_OUT, 16'd2);
    send_ticks(1);
    send_fade(MODE_IN, 32'h0, 32'h0, 16'd0);
    send_fade(MODE_IN, 32'h0, 32'h0, 16'd5);
    send_ticks(5);
  endtask

  task automatic run_random_mix();
    int base;
    int pick;
    int lim;
    logic [1:0] req;
    logic [15:0] len;
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 90) begin
        req = ($urandom_range(0, 99) < 70) ? MODE_OUT : MODE_IN;
        len = pick_length();
        lim = (len > 16'd40) ? 40 : int'(len);
        send_mode(req, len);
        if (pick < 75) send_ticks(lim + $urandom_range(0, 1));
        else send_ticks($urandom_range(0, lim));
      end else begin
        repeat ($urandom_range(1, 3)) send_mode(2'($urandom_range(0, 3)), 16'($urandom));
      end
    end
  endtask

  initial begin : result_sink
    fade_result_t got;
    forever begin
      @(negedge clk_i);
      if (!pressure_done && ramp_sb.results_seen >= 100) begin
        pressure_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_stall_i <= !(ramp_sb.results_seen >= 180 && ramp_sb.results_seen < 280) &&
                     ($urandom_range(0, 99) < IDLE_PERCENT);
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.colour   = {alpha_out_o, blue_out_o, green_out_o, red_out_o};
        got.busy     = busy_res_o;
        got.shown    = shown_o;
        got.finished = finished_o;
        ramp_sb.check_colour(got);
      end
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    run_directed();
    run_random_mix();
    in_valid_i <= 1'b0;
    while (ramp_sb.pending_colours.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d transactions: %0d fade-out, %0d fade-in, %0d ticks, %0d unused",
             items_sent, ramp_sb.mode_count[MODE_OUT], ramp_sb.mode_count[MODE_IN],
             ramp_sb.mode_count[MODE_TICK], ramp_sb.mode_count[MODE_UNUSED]);
    $display("%0d fades completed, %0d results checked, %0d failures",
             ramp_sb.fades_done, ramp_sb.results_seen, ramp_sb.errors);
    if (ramp_sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("timeout with %0d results outstanding", ramp_sb.pending_colours.size());
    $display("FAIL");
    $finish;
  end

endmodule

### rgba_linear_fade_ramp_top.f
rtl/core/rlfr_pkg.sv
rtl/core/rlfr_div.sv
rtl/core/rgba_linear_fade_ramp_top.sv
bench/rgba_linear_fade_ramp_top_tb.sv
